// ===== hdl/vca_pkg.sv =====
// Shared widths, field offsets, command codes and types for the voice channel allocator.
package vca_pkg;

  localparam int NUM_CHANNELS_DEF  = 8;
  localparam int SOUND_ID_BITS_DEF = 8;

  localparam int CMD_W      = 3;
  localparam int SOUND_IN_W = 8;
  localparam int HANDLE_W   = 32;
  localparam int MASK_W     = 8;
  localparam int CHAN_OUT_W = 3;
  localparam int STATE_W    = 2;

  // input tdata layout
  localparam int IN_SND_LSB  = 0;
  localparam int IN_LOOP_BIT = IN_SND_LSB + SOUND_IN_W;
  localparam int IN_HND_LSB  = IN_LOOP_BIT + 1;
  localparam int IN_MASK_LSB = IN_HND_LSB + HANDLE_W;
  localparam int IN_USED_W   = IN_MASK_LSB + MASK_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // output tdata layout
  localparam int OUT_HND_LSB = 0;
  localparam int OUT_CH_LSB  = OUT_HND_LSB + HANDLE_W;
  localparam int OUT_ST_LSB  = OUT_CH_LSB + CHAN_OUT_W;
  localparam int OUT_USED_W  = OUT_ST_LSB + STATE_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PLAY     = 3'd0,
    CMD_STOP     = 3'd1,
    CMD_PAUSE    = 3'd2,
    CMD_RESUME   = 3'd3,
    CMD_QUERY    = 3'd4,
    CMD_STOP_ALL = 3'd5,
    CMD_TICK     = 3'd6
  } cmd_e;

  localparam logic [STATE_W-1:0] SND_STOPPED = 2'd0;
  localparam logic [STATE_W-1:0] SND_PLAYING = 2'd1;
  localparam logic [STATE_W-1:0] SND_PAUSED  = 2'd2;

  // result of the shared handle comparator
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

// ===== hdl/vca_cmp.sv =====
// Shared handle comparator: equality for lookups, unsigned less-than for stealing.
module vca_cmp (
  input  logic [vca_pkg::HANDLE_W-1:0] a_i,
  input  logic [vca_pkg::HANDLE_W-1:0] b_i,
  output vca_pkg::cmp_res_t            res_o
);
  import vca_pkg::*;

  assign res_o.eq = (a_i == b_i);
  assign res_o.lt = (a_i < b_i);

endmodule

// ===== hdl/voice_channel_allocator.sv =====
// Top level of the voice channel allocator: channel table, scan sequencer and result register.
//
//  channel   | dir | tdata (low bit up)                              | tuser
//  ----------+-----+-------------------------------------------------+----------------
//  s_axis    | in  | sound_id, loop_flag, handle_in, playing_mask    | cmd
//  m_axis    | out | handle_out, channel_out, sound_state            | unknown_handle
//
// Play, stop, pause, resume and query walk the channel table one entry per cycle
// through the single handle comparator: an accept step, a scan of up to NUM_CHANNELS
// entries and an update step, then the result waits in the output register (a hit
// or a free channel ends the walk early). Stop-all and tick update the table on
// accept and go straight to the output register.
// s_axis_tready_o is high only while no item is in flight; a stalled m_axis holds
// the result and the block. Reset empties the table and zeroes the handle counter.
module voice_channel_allocator #(
  parameter int NUM_CHANNELS  = vca_pkg::NUM_CHANNELS_DEF,
  parameter int SOUND_ID_BITS = vca_pkg::SOUND_ID_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // sound_id[7:0], loop_flag[8], handle_in[40:9], playing_mask[48:41], zero pad
  input  logic [vca_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // cmd[2:0]
  input  logic [vca_pkg::CMD_W-1:0]        s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // handle_out[31:0], channel_out[34:32], sound_state[36:35], zero pad
  output logic [vca_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // unknown_handle[0]
  output logic                             m_axis_tuser_o
);
  import vca_pkg::*;

  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int MX_W  = (NUM_CHANNELS > MASK_W) ? NUM_CHANNELS : MASK_W;
  localparam int SX_W  = (SOUND_ID_BITS > SOUND_IN_W) ? SOUND_ID_BITS : SOUND_IN_W;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0] state_q;

  // channel table
  logic [NUM_CHANNELS-1:0]  valid_q;
  logic [NUM_CHANNELS-1:0]  looping_q;
  logic [NUM_CHANNELS-1:0]  paused_q;
  logic [HANDLE_W-1:0]      handle_mem_q [NUM_CHANNELS];
  logic [SOUND_ID_BITS-1:0] sound_mem_q  [NUM_CHANNELS];
  logic [HANDLE_W-1:0]      last_handle_q;

  // latched command
  cmd_e                     cmd_q;
  logic [SOUND_ID_BITS-1:0] snd_q;
  logic                     loop_q;
  logic [HANDLE_W-1:0]      hin_q;

  // scan bookkeeping
  logic [CH_W-1:0]     idx_q;
  logic                free_found_q;
  logic [CH_W-1:0]     free_ch_q;
  logic                best_found_q;
  logic [CH_W-1:0]     best_ch_q;
  logic [1:0]          best_rank_q;
  logic [HANDLE_W-1:0] best_handle_q;
  logic                hit_q;
  logic [CH_W-1:0]     hit_ch_q;

  // result register
  logic [HANDLE_W-1:0]   out_handle_q;
  logic [CHAN_OUT_W-1:0] out_ch_q;
  logic [STATE_W-1:0]    out_state_q;
  logic                  out_unk_q;

  // unpack the input item
  logic [SX_W-1:0]          snd_ext;
  logic [SOUND_ID_BITS-1:0] in_snd;
  logic [MX_W-1:0]          mask_ext;
  logic                     in_accept;

  assign snd_ext   = SX_W'(s_axis_tdata_i[IN_SND_LSB +: SOUND_IN_W]);
  assign in_snd    = snd_ext[SOUND_ID_BITS-1:0];
  // channels past the mask width read as not playing
  assign mask_ext  = MX_W'(s_axis_tdata_i[IN_MASK_LSB +: MASK_W]);
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  // entry under the scan pointer
  logic                     ent_valid;
  logic                     ent_looping;
  logic [HANDLE_W-1:0]      ent_handle;
  logic [SOUND_ID_BITS-1:0] ent_sound;
  logic [HANDLE_W-1:0]      cmp_b;
  cmp_res_t                 cmp_res;
  logic [1:0]               ent_rank;
  logic                     ent_better;
  logic                     scan_last;

  assign ent_valid   = valid_q[idx_q];
  assign ent_looping = looping_q[idx_q];
  assign ent_handle  = handle_mem_q[idx_q];
  assign ent_sound   = sound_mem_q[idx_q];
  assign scan_last   = (idx_q == LAST_CH);

  // one comparator serves both the stealing order and the handle lookup
  assign cmp_b = (cmd_q == CMD_PLAY) ? best_handle_q : hin_q;

  vca_cmp u_cmp (
    .a_i   (ent_handle),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  // steal preference: same sound, then looping, then anything; oldest handle within a class
  always_comb begin
    if (ent_sound == snd_q) begin
      ent_rank = 2'd2;
    end else if (ent_looping) begin
      ent_rank = 2'd1;
    end else begin
      ent_rank = 2'd0;
    end
    ent_better = !best_found_q || (ent_rank > best_rank_q) ||
                 ((ent_rank == best_rank_q) && cmp_res.lt);
  end

  // commit values for the update cycle
  logic [CH_W-1:0]     play_ch;
  logic [HANDLE_W-1:0] next_handle;
  logic [CH_W-1:0]     apply_ch;
  logic [CH_W+2:0]     apply_ch_ext;
  logic                play_commit;

  assign play_ch      = free_found_q ? free_ch_q : best_ch_q;
  assign next_handle  = (last_handle_q == {HANDLE_W{1'b1}}) ? HANDLE_W'(1)
                                                             : last_handle_q + HANDLE_W'(1);
  assign apply_ch     = (cmd_q == CMD_PLAY) ? play_ch : hit_ch_q;
  assign apply_ch_ext = {3'b000, apply_ch};
  assign play_commit  = (state_q == S_APPLY) && (cmd_q == CMD_PLAY);

  // handle and sound stores: written only by a play commit
  always_ff @(posedge clk_i) begin
    if (play_commit) begin
      handle_mem_q[play_ch] <= next_handle;
      sound_mem_q[play_ch]  <= snd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      valid_q       <= '0;
      looping_q     <= '0;
      paused_q      <= '0;
      last_handle_q <= '0;
      cmd_q         <= CMD_PLAY;
      snd_q         <= '0;
      loop_q        <= 1'b0;
      hin_q         <= '0;
      idx_q         <= '0;
      free_found_q  <= 1'b0;
      free_ch_q     <= '0;
      best_found_q  <= 1'b0;
      best_ch_q     <= '0;
      best_rank_q   <= '0;
      best_handle_q <= '0;
      hit_q         <= 1'b0;
      hit_ch_q      <= '0;
      out_handle_q  <= '0;
      out_ch_q      <= '0;
      out_state_q   <= SND_STOPPED;
      out_unk_q     <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            cmd_q        <= cmd_e'(s_axis_tuser_i);
            snd_q        <= in_snd;
            loop_q       <= s_axis_tdata_i[IN_LOOP_BIT];
            hin_q        <= s_axis_tdata_i[IN_HND_LSB +: HANDLE_W];
            idx_q        <= '0;
            free_found_q <= 1'b0;
            best_found_q <= 1'b0;
            hit_q        <= 1'b0;
            out_handle_q <= '0;
            out_ch_q     <= '0;
            out_state_q  <= SND_STOPPED;
            out_unk_q    <= 1'b0;
            case (cmd_e'(s_axis_tuser_i))
              CMD_PLAY, CMD_STOP, CMD_PAUSE, CMD_RESUME, CMD_QUERY: begin
                state_q <= S_SCAN;
              end
              CMD_STOP_ALL: begin
                valid_q <= '0;
                state_q <= S_OUT;
              end
              CMD_TICK: begin
                valid_q <= valid_q & mask_ext[NUM_CHANNELS-1:0];
                state_q <= S_OUT;
              end
              default: begin
                state_q <= S_OUT;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (cmd_q == CMD_PLAY) begin
            if (!ent_valid) begin
              // first free channel wins outright
              free_found_q <= 1'b1;
              free_ch_q    <= idx_q;
              state_q      <= S_APPLY;
            end else begin
              if (ent_better) begin
                best_found_q  <= 1'b1;
                best_ch_q     <= idx_q;
                best_rank_q   <= ent_rank;
                best_handle_q <= ent_handle;
              end
              if (scan_last) begin
                state_q <= S_APPLY;
              end else begin
                idx_q <= idx_q + CH_W'(1);
              end
            end
          end else begin
            if (ent_valid && cmp_res.eq) begin
              hit_q    <= 1'b1;
              hit_ch_q <= idx_q;
              state_q  <= S_APPLY;
            end else if (scan_last) begin
              state_q <= S_APPLY;
            end else begin
              idx_q <= idx_q + CH_W'(1);
            end
          end
        end

        S_APPLY: begin
          state_q <= S_OUT;
          case (cmd_q)
            CMD_PLAY: begin
              valid_q[play_ch]   <= 1'b1;
              looping_q[play_ch] <= loop_q;
              paused_q[play_ch]  <= 1'b0;
              last_handle_q      <= next_handle;
              out_handle_q       <= next_handle;
              out_ch_q           <= apply_ch_ext[CHAN_OUT_W-1:0];
            end
            CMD_STOP, CMD_PAUSE, CMD_RESUME, CMD_QUERY: begin
              if (hit_q) begin
                out_ch_q <= apply_ch_ext[CHAN_OUT_W-1:0];
                case (cmd_q)
                  CMD_STOP:   valid_q[hit_ch_q]  <= 1'b0;
                  CMD_PAUSE:  paused_q[hit_ch_q] <= 1'b1;
                  CMD_RESUME: paused_q[hit_ch_q] <= 1'b0;
                  default: begin
                    out_state_q <= paused_q[hit_ch_q] ? SND_PAUSED : SND_PLAYING;
                  end
                endcase
              end else begin
                // a query of an unknown handle just reports stopped
                out_unk_q <= (cmd_q != CMD_QUERY);
              end
            end
            default: begin
            end
          endcase
        end

        S_OUT: begin
          if (m_axis_tready_i) begin
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_state_q, out_ch_q, out_handle_q});
  assign m_axis_tuser_o  = out_unk_q;

endmodule
